@@ src/tlcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_pkg: shared types and constants
// Field widths, register indexes and the band record for the character
// segmenter.
// ----------------------------------------------------------------------------
package tlcs_pkg;

   localparam int RED_W      = 8;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 7;
   localparam int WIDTH_W    = 8;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // One closed band waiting for the column scan.
   typedef struct packed {
      logic [ROW_W-1:0]   top;
      logic [ROW_W-1:0]   bottom;
      logic [WIDTH_W-1:0] width;
   } band_meta_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

@@ src/tlcs_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_ifs: channel interfaces
// Pixel, box and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tlcs_pixel_if;
   logic                     valid;
   logic                     ready;
   logic [tlcs_pkg::RED_W-1:0] red;
   modport source (output valid, output red, input ready);
   modport sink   (input valid, input red, output ready);
endinterface

interface tlcs_box_if;
   logic                       valid;
   logic                       ready;
   logic [tlcs_pkg::ROW_W-1:0] box_top;
   logic [tlcs_pkg::ROW_W-1:0] box_bottom;
   logic [tlcs_pkg::COL_W-1:0] box_left;
   logic [tlcs_pkg::COL_W-1:0] box_right;
   logic                       last_box;
   modport source (output valid, output box_top, output box_bottom, output box_left,
                   output box_right, output last_box, input ready);
   modport sink   (input valid, input box_top, input box_bottom, input box_left,
                   input box_right, input last_box, output ready);
endinterface

interface tlcs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tlcs_pkg::CSR_IDX_W-1:0]  index;
   logic [tlcs_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/tlcs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_front: pixel classifier and band tracker
// Walks the raster, ORs ink into the column marks and hands a snapshot of
// the marks to the queue when a blank row closes a band.
// ----------------------------------------------------------------------------
module tlcs_front #(
   parameter int MAX_WIDTH = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [tlcs_pkg::RED_W-1:0]     red,
   input  logic [tlcs_pkg::WIDTH_W-1:0]   w_eff,
   input  logic [tlcs_pkg::HEIGHT_W-1:0]  h_eff,
   output logic                           push,
   output tlcs_pkg::band_meta_type        push_meta,
   output logic [MAX_WIDTH-1:0]           push_marks
);
   import tlcs_pkg::*;

   localparam int CIDX_W = $clog2(MAX_WIDTH);

   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 row_ink_ff, row_ink_in;
   logic                 band_open_ff, band_open_in;
   logic [ROW_W-1:0]     band_top_ff, band_top_in;
   logic [MAX_WIDTH-1:0] marks_ff, marks_in;

   logic [COL_W-1:0] col;
   logic             last_col;
   logic             last_row;
   logic             ink;
   logic             ink_now;
   logic             open_now;

   always_comb begin
      col      = ({1'b0, col_ff} >= w_eff) ? COL_W'(w_eff - 8'd1) : col_ff;
      last_col = (({1'b0, col} + 8'd1) >= w_eff);
      last_row = (({1'b0, row_ff} + 13'd1) >= h_eff);
      ink      = (red == '0);
      ink_now  = row_ink_ff | ink;
      open_now = band_open_ff | ink;

      col_in       = col_ff;
      row_in       = row_ff;
      row_ink_in   = row_ink_ff;
      band_open_in = band_open_ff;
      band_top_in  = band_top_ff;
      marks_in     = marks_ff;
      push         = 1'b0;

      if (accept) begin
         if (ink) begin
            marks_in = marks_ff | (MAX_WIDTH'(1) << col[CIDX_W-1:0]);
            if (!band_open_ff) begin
               band_open_in = 1'b1;
               band_top_in  = row_ff;
            end
         end
         if (last_col) begin
            if (!ink_now && open_now) begin
               push         = 1'b1;
               marks_in     = '0;
               band_open_in = 1'b0;
            end
            row_ink_in = 1'b0;
            col_in     = '0;
            if (last_row) begin
               row_in       = '0;
               band_open_in = 1'b0;
               marks_in     = '0;
            end else begin
               row_in = row_ff + 12'd1;
            end
         end else begin
            row_ink_in = ink_now;
            col_in     = col + 7'd1;
         end
      end
   end

   assign push_meta.top    = band_top_ff;
   assign push_meta.bottom = row_ff;
   assign push_meta.width  = w_eff;
   assign push_marks       = marks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         row_ink_ff   <= 1'b0;
         band_open_ff <= 1'b0;
         band_top_ff  <= '0;
         marks_ff     <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_ink_ff   <= row_ink_in;
         band_open_ff <= band_open_in;
         band_top_ff  <= band_top_in;
         marks_ff     <= marks_in;
      end
   end

endmodule

@@ src/tlcs_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_queue: two-entry band queue
// Holds closed bands between the front tracker and the column scanner.
// ----------------------------------------------------------------------------
module tlcs_queue #(
   parameter int MAX_WIDTH = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tlcs_pkg::band_meta_type   push_meta,
   input  logic [MAX_WIDTH-1:0]      push_marks,
   input  logic                      pop,
   output tlcs_pkg::queue_status_type status,
   output tlcs_pkg::band_meta_type   head_meta,
   output logic [MAX_WIDTH-1:0]      head_marks
);
   import tlcs_pkg::*;

   band_meta_type        meta_ff [2];
   logic [MAX_WIDTH-1:0] marks_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign head_meta    = meta_ff[rd_ptr_ff];
   assign head_marks   = marks_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         meta_ff[wr_ptr_ff]  <= push_meta;
         marks_ff[wr_ptr_ff] <= push_marks;
      end
   end

endmodule

@@ src/tlcs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_back: column scanner
// Steps through one band's column marks a column per cycle while boxes
// drain, and emits a box for each inked run closed by an empty column.
// ----------------------------------------------------------------------------
module tlcs_back #(
   parameter int MAX_WIDTH = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tlcs_pkg::queue_status_type status,
   input  tlcs_pkg::band_meta_type    head_meta,
   input  logic [MAX_WIDTH-1:0]       head_marks,
   output logic                       pop,
   tlcs_box_if.source                 rsp
);
   import tlcs_pkg::*;

   localparam int CIDX_W = $clog2(MAX_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [COL_W-1:0] idx_ff, idx_in;
   logic             in_run_ff, in_run_in;
   logic [COL_W-1:0] start_ff, start_in;
   logic             pend_ff, pend_in;
   logic [COL_W-1:0] pend_left_ff, pend_left_in;
   logic [COL_W-1:0] pend_right_ff, pend_right_in;

   logic             out_valid_ff, out_valid_in;
   logic [ROW_W-1:0] out_top_ff, out_top_in;
   logic [ROW_W-1:0] out_bottom_ff, out_bottom_in;
   logic [COL_W-1:0] out_left_ff, out_left_in;
   logic [COL_W-1:0] out_right_ff, out_right_in;
   logic             out_last_ff, out_last_in;

   logic             slot_free;
   logic             bit_now;
   logic             run_end;
   logic             emit;
   logic             emit_last;
   logic [COL_W-1:0] last_idx;

   always_comb begin
      slot_free = !out_valid_ff || rsp.ready;
      bit_now   = head_marks[idx_ff[CIDX_W-1:0]];
      run_end   = in_run_ff && !bit_now;
      last_idx  = COL_W'(head_meta.width - 8'd1);

      state_in      = state_ff;
      idx_in        = idx_ff;
      in_run_in     = in_run_ff;
      start_in      = start_ff;
      pend_in       = pend_ff;
      pend_left_in  = pend_left_ff;
      pend_right_in = pend_right_ff;
      pop           = 1'b0;
      emit          = 1'b0;
      emit_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (status.valid) begin
               state_in  = ST_SCAN;
               idx_in    = '0;
               in_run_in = 1'b0;
               pend_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            if (!(run_end && pend_ff && !slot_free)) begin
               if (bit_now && !in_run_ff) begin
                  in_run_in = 1'b1;
                  start_in  = idx_ff;
               end
               if (run_end) begin
                  emit          = pend_ff;
                  pend_in       = 1'b1;
                  pend_left_in  = start_ff;
                  pend_right_in = idx_ff;
                  in_run_in     = 1'b0;
               end
               if (idx_ff == last_idx) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + 7'd1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_ff || slot_free) begin
               emit      = pend_ff;
               emit_last = 1'b1;
               pend_in   = 1'b0;
               pop       = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in  = emit ? 1'b1 : (out_valid_ff && !rsp.ready);
      out_top_in    = emit ? head_meta.top : out_top_ff;
      out_bottom_in = emit ? head_meta.bottom : out_bottom_ff;
      out_left_in   = emit ? pend_left_ff : out_left_ff;
      out_right_in  = emit ? pend_right_ff : out_right_ff;
      out_last_in   = emit ? emit_last : out_last_ff;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.box_top    = out_top_ff;
   assign rsp.box_bottom = out_bottom_ff;
   assign rsp.box_left   = out_left_ff;
   assign rsp.box_right  = out_right_ff;
   assign rsp.last_box   = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_run_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         in_run_ff    <= in_run_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      pend_left_ff  <= pend_left_in;
      pend_right_ff <= pend_right_in;
      out_top_ff    <= out_top_in;
      out_bottom_ff <= out_bottom_in;
      out_left_ff   <= out_left_in;
      out_right_ff  <= out_right_in;
      out_last_ff   <= out_last_in;
   end

endmodule

@@ src/text_line_char_segmenter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_char_segmenter: projection-profile character segmentation
// Finds text bands in a raster pixel stream and reports one box per
// character found by the column ink profile of each band.
// ----------------------------------------------------------------------------
// The block takes one pixel per cycle on req_ch while the queue has
// room and keeps taking pixels while earlier bands are still being
// scanned. When a blank row closes a band, its column marks are copied
// into a two-entry queue; the scanner then picks the band up, walks its
// marks one column per cycle unless rsp_ch holds off a waiting box, and
// hands off the last box. req_ch.ready drops only while two closed bands
// sit in the queue; the band under scan keeps its entry until its last
// box has moved to the output stage. Boxes come out of a registered
// output stage in left-to-right order, last_box set on the final box of
// each band. A band still open at the bottom of the image, and a
// character that touches the right edge, give no box. Registers on
// csr_ch (image_width at index 0, image_height at index 1) are taken
// every cycle; image_width keeps the low 8 bits of its data, and
// out-of-range values clamp to 1 or to the maximum.
// ----------------------------------------------------------------------------
module text_line_char_segmenter #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   tlcs_pixel_if.sink  req_ch,
   tlcs_box_if.source  rsp_ch,
   tlcs_csr_if.sink    csr_ch
);
   import tlcs_pkg::*;

   // configuration registers
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;

   // effective (clamped) frame size
   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;

   logic                 accept;
   logic                 push;
   band_meta_type        push_meta;
   logic [MAX_WIDTH-1:0] push_marks;
   logic                 pop;
   queue_status_type     q_status;
   band_meta_type        head_meta;
   logic [MAX_WIDTH-1:0] head_marks;

   // register writes: every transfer is taken, unknown indexes are ignored
   assign csr_ch.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_IMAGE_WIDTH:  width_in  = csr_ch.data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_W'(MAX_WIDTH);
         height_ff <= HEIGHT_W'(MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // zero acts as one, anything past the maximum acts as the maximum
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // front side stalls only when the band queue is full
   assign req_ch.ready = !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   tlcs_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .red        (req_ch.red),
      .w_eff      (w_eff),
      .h_eff      (h_eff),
      .push       (push),
      .push_meta  (push_meta),
      .push_marks (push_marks)
   );

   tlcs_queue #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_meta  (push_meta),
      .push_marks (push_marks),
      .pop        (pop),
      .status     (q_status),
      .head_meta  (head_meta),
      .head_marks (head_marks)
   );

   tlcs_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (q_status),
      .head_meta  (head_meta),
      .head_marks (head_marks),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

@@ src/tlcs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_checker: port-level checks
// Watches the box channel of the segmenter for ordering and hold rules.
// ----------------------------------------------------------------------------
module tlcs_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [tlcs_pkg::ROW_W-1:0] box_top,
   input logic [tlcs_pkg::ROW_W-1:0] box_bottom,
   input logic [tlcs_pkg::COL_W-1:0] box_left,
   input logic [tlcs_pkg::COL_W-1:0] box_right
);

   // a stalled box stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("box dropped while stalled");

   // nothing offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("box offered after reset");

   // a character spans at least one column
   a_col_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (box_left < box_right))
      else $error("box left edge not before right edge");

   // the closing blank row lies below the band top
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (box_top < box_bottom))
      else $error("box top not above bottom");

endmodule

bind text_line_char_segmenter tlcs_checker u_tlcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .box_top    (rsp_ch.box_top),
   .box_bottom (rsp_ch.box_bottom),
   .box_left   (rsp_ch.box_left),
   .box_right  (rsp_ch.box_right)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: character segmenter testbench
// Streams raster images through the segmenter under a series of width and
// height settings and flow-control patterns. A local model tracks the bands
// and column marks, predicts every box, and each box transfer is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import tlcs_pkg::*;

   localparam int IMG_MAX_W     = 128;
   localparam int IMG_MAX_H     = 4096;
   // Two bands can wait in the queue; each scans a column per cycle unless stalled.
   localparam int SCAN_SETTLE   = 3 * IMG_MAX_W;
   localparam int HOLD_CYCLES   = 3000;

   // Flow-control patterns applied per phase.
   typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_mode_type;

   typedef struct packed {
      logic [ROW_W-1:0] top;
      logic [ROW_W-1:0] bottom;
      logic [COL_W-1:0] left;
      logic [COL_W-1:0] right;
      logic             last;
   } char_box_type;

   // Directed image, 3 columns by 7 rows over a 5-row frame, one row per line:
   //   ink in cols 0 and 2, then blank: one box for col 0, col 2 touches the edge
   //   ink in col 1 only (with near-blank values around it), then blank: one box
   //   ink on the last row of the frame: band dropped at the image bottom
   //   next frame, ink only at the right edge, then blank: band gives no box
   localparam logic [RED_W-1:0] DIRECTED_PIXELS [21] = '{
      8'd0,   8'd255, 8'd0,
      8'd255, 8'd255, 8'd255,
      8'd128, 8'd0,   8'd127,
      8'd254, 8'd1,   8'd255,
      8'd0,   8'd0,   8'd255,
      8'd255, 8'd255, 8'd0,
      8'd255, 8'd255, 8'd255
   };

   // Inked row for the back-pressure phase: two boxes per band on 5 columns.
   localparam logic [RED_W-1:0] PRESSURE_ROW [5] = '{
      8'd0, 8'd255, 8'd0, 8'd255, 8'd255
   };

   logic clock = 1'b0;
   logic reset;

   tlcs_pixel_if pix_ch ();
   tlcs_box_if   box_ch ();
   tlcs_csr_if   reg_ch ();

   text_line_char_segmenter #(
      .MAX_WIDTH  (IMG_MAX_W),
      .MAX_HEIGHT (IMG_MAX_H)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (pix_ch),
      .rsp_ch (box_ch),
      .csr_ch (reg_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Stimulus and scoreboard state
   // ---------------------------------------------------------------------
   logic [RED_W-1:0] pixels_to_send [$];
   char_box_type     pending_boxes [$];
   int unsigned      pixels_queued   = 0;
   int unsigned      pixels_accepted = 0;
   int unsigned      boxes_checked   = 0;
   int unsigned      error_count     = 0;

   int unsigned send_gap_pct   = 0;
   int unsigned recv_stall_pct = 0;
   logic        pressure_on    = 1'b0;
   int unsigned hold_count     = 0;
   wire         holding_off    = pressure_on && (hold_count < HOLD_CYCLES);

   // Segmenter model state, starting at its reset values.
   logic [WIDTH_W-1:0]   cfg_width  = WIDTH_W'(IMG_MAX_W);
   logic [HEIGHT_W-1:0]  cfg_height = HEIGHT_W'(IMG_MAX_H);
   int unsigned          col_pos    = 0;
   int unsigned          row_pos    = 0;
   bit                   row_ink    = 1'b0;
   bit                   band_open  = 1'b0;
   int unsigned          band_top   = 0;
   logic [IMG_MAX_W-1:0] column_ink = '0;

   // Out-of-range register values clamp to 1 or to the maximum.
   function automatic int unsigned active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > IMG_MAX_W) return IMG_MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned active_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > IMG_MAX_H) return IMG_MAX_H;
      return cfg_height;
   endfunction

   // Advance the model by one pixel and queue the boxes it closes.
   function automatic void segment_pixel(input logic [RED_W-1:0] red);
      int unsigned  w;
      int unsigned  h;
      int unsigned  col;
      int unsigned  run_start;
      bit           in_run;
      bit           have_box;
      char_box_type held;
      w = active_width();
      h = active_height();
      // a position left beyond a narrowed row counts as its last column
      col = (col_pos >= w) ? w - 1 : col_pos;
      if (red == '0) begin
         row_ink         = 1'b1;
         column_ink[col] = 1'b1;
         if (!band_open) begin
            band_open = 1'b1;
            band_top  = row_pos;
         end
      end
      if (col + 1 >= w) begin
         // first blank row closes the band: one box per run of marked
         // columns that an empty column ends; a run at the edge is lost
         if (!row_ink && band_open) begin
            in_run    = 1'b0;
            have_box  = 1'b0;
            run_start = 0;
            held      = '0;
            for (int i = 0; i < w; i++) begin
               if (column_ink[i]) begin
                  if (!in_run) begin
                     in_run    = 1'b1;
                     run_start = i;
                  end
               end else if (in_run) begin
                  if (have_box) pending_boxes.push_back(held);
                  held.top    = band_top[ROW_W-1:0];
                  held.bottom = row_pos[ROW_W-1:0];
                  held.left   = run_start[COL_W-1:0];
                  held.right  = i[COL_W-1:0];
                  held.last   = 1'b0;
                  have_box    = 1'b1;
                  in_run      = 1'b0;
               end
            end
            if (have_box) begin
               held.last = 1'b1;
               pending_boxes.push_back(held);
            end
            column_ink = '0;
            band_open  = 1'b0;
         end
         row_ink = 1'b0;
         col_pos = 0;
         // bottom of the image: an open band is dropped
         if (row_pos + 1 >= h) begin
            row_pos    = 0;
            band_open  = 1'b0;
            column_ink = '0;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col + 1;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("box %0d %s: got %0d, expected %0d",
                                   boxes_checked, field, got, want));
   endtask

   // ---------------------------------------------------------------------
   // Pixel driver: holds each pixel until its transfer, idles between
   // pixels at the phase's gap rate.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         pix_ch.valid <= 1'b0;
      end else if (!pix_ch.valid || pix_ch.ready) begin
         if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            pix_ch.valid <= 1'b1;
            pix_ch.red   <= pixels_to_send.pop_front();
         end else begin
            pix_ch.valid <= 1'b0;
         end
      end
   end

   // Pixel monitor: every transfer steps the model; count last so that a
   // waiter seeing the new count also sees the boxes it produced.
   always @(posedge clock) begin
      if (!reset && pix_ch.valid && pix_ch.ready) begin
         segment_pixel(pix_ch.red);
         pixels_accepted++;
      end
   end

   // Long hold-off for the back-pressure phase, counted here.
   always @(posedge clock) begin
      if (!pressure_on) begin
         hold_count <= 0;
      end else if (hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
      end
   end

   // Box receiver: random stalls, plus the hold-off when it is active.
   always @(posedge clock) begin
      if (reset) begin
         box_ch.ready <= 1'b0;
      end else begin
         box_ch.ready <= !(holding_off || $urandom_range(99) < recv_stall_pct);
      end
   end

   // Box checker: each box transfer against the oldest prediction.
   always @(posedge clock) begin : box_check
      char_box_type want;
      if (!reset && box_ch.valid && box_ch.ready) begin
         if (pending_boxes.size() == 0) begin
            report_mismatch($sformatf("unexpected box top %0d bottom %0d left %0d right %0d",
                                      box_ch.box_top, box_ch.box_bottom,
                                      box_ch.box_left, box_ch.box_right));
         end else begin
            want = pending_boxes.pop_front();
            check_field("box_top",    16'(box_ch.box_top),    16'(want.top));
            check_field("box_bottom", 16'(box_ch.box_bottom), 16'(want.bottom));
            check_field("box_left",   16'(box_ch.box_left),   16'(want.left));
            check_field("box_right",  16'(box_ch.box_right),  16'(want.right));
            check_field("last_box",   16'(box_ch.last_box),   16'(want.last));
         end
         boxes_checked++;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_pixel(input logic [RED_W-1:0] red);
      pixels_to_send.push_back(red);
      pixels_queued++;
   endtask

   // One register write transfer; the model takes the value at the same edge.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      reg_ch.valid <= 1'b1;
      reg_ch.index <= idx;
      reg_ch.data  <= value;
      do @(posedge clock); while (!reg_ch.ready);
      reg_ch.valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  cfg_width  = value[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: cfg_height = value[HEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   // Reprogram the image size on an idle block, pick the flow pattern and
   // pad out any row left half done so the bands below start on a row.
   task automatic start_phase(input logic [CSR_DATA_W-1:0] width_val,
                              input logic [CSR_DATA_W-1:0] height_val,
                              input flow_mode_type mode);
      int unsigned w;
      int unsigned pad;
      write_reg(CSR_IMAGE_WIDTH, width_val);
      write_reg(CSR_IMAGE_HEIGHT, height_val);
      case (mode)
         FLOW_FREE: begin
            send_gap_pct   <= 0;
            recv_stall_pct <= 0;
         end
         FLOW_SEND_GAPS: begin
            send_gap_pct   <= 80;
            recv_stall_pct <= 0;
         end
         FLOW_RECV_STALLS: begin
            send_gap_pct   <= 0;
            recv_stall_pct <= 80;
         end
         default: begin
            send_gap_pct   <= 6;
            recv_stall_pct <= 6;
         end
      endcase
      w   = active_width();
      pad = 0;
      if (col_pos != 0) pad = (col_pos >= w) ? 1 : w - col_pos;
      repeat (pad) queue_pixel(RED_W'($urandom_range(1, 255)));
   endtask

   // Bands of 1..3 inked rows closed by a blank row. Some are preceded by a
   // noise row, some run into the next band unclosed; a ragged tail leaves
   // the row position mid-row for the next register write.
   task automatic queue_bands(input int count);
      int unsigned w;
      int unsigned rows;
      int unsigned ink_pct;
      w = active_width();
      repeat (count) begin
         if ($urandom_range(5) == 0)
            repeat (w)
               queue_pixel(RED_W'(($urandom_range(3) == 0) ? 0 : $urandom_range(255)));
         rows    = $urandom_range(1, 3);
         ink_pct = $urandom_range(15, 60);
         repeat (rows)
            repeat (w)
               queue_pixel(RED_W'(($urandom_range(99) < ink_pct) ? 0
                                                                 : $urandom_range(1, 255)));
         if ($urandom_range(7) != 0) repeat (w) queue_pixel(RED_W'($urandom_range(1, 255)));
      end
      repeat ($urandom_range(w - 1))
         queue_pixel(RED_W'(($urandom_range(3) == 0) ? 0 : $urandom_range(255)));
   endtask

   // Wait for every pixel transfer and every predicted box, then give the
   // scanner time to finish bands that close without a box.
   task automatic finish_phase();
      while (pixels_accepted != pixels_queued || pending_boxes.size() != 0)
         @(posedge clock);
      repeat (SCAN_SETTLE) @(posedge clock);
      pressure_on <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      pix_ch.valid = 1'b0;
      pix_ch.red   = '0;
      box_ch.ready = 1'b0;
      reg_ch.valid = 1'b0;
      reg_ch.index = CSR_IMAGE_WIDTH;
      reg_ch.data  = '0;
      reset        = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed image: edge-touching run, dropped band, band with no box
      start_phase(3, 5, FLOW_FREE);
      foreach (DIRECTED_PIXELS[i]) queue_pixel(DIRECTED_PIXELS[i]);
      finish_phase();

      // short frames so that bands run off the bottom
      start_phase(5, 7, FLOW_SEND_GAPS);
      queue_bands(2);
      finish_phase();

      // height above the maximum clamps
      start_phase(6, 8191, FLOW_RECV_STALLS);
      queue_bands(2);
      finish_phase();

      // one-column rows: every run touches the edge
      start_phase(1, 3, FLOW_BOTH);
      queue_bands(4);
      finish_phase();

      // zero width and height act as one
      start_phase(0, 0, FLOW_BOTH);
      queue_bands(2);
      finish_phase();

      // width above the maximum clamps to full-width rows: one inked row
      // closed by a blank row
      start_phase(200, 9, FLOW_BOTH);
      repeat (IMG_MAX_W)
         queue_pixel(RED_W'(($urandom_range(2) == 0) ? 0 : $urandom_range(1, 255)));
      repeat (IMG_MAX_W) queue_pixel(RED_W'($urandom_range(1, 255)));
      finish_phase();

      // back-pressure: boxes held off while pixels keep coming, so the
      // band queue fills and the pixel input stalls
      start_phase(5, 64, FLOW_FREE);
      pressure_on <= 1'b1;
      repeat (4) begin
         foreach (PRESSURE_ROW[i]) queue_pixel(PRESSURE_ROW[i]);
         repeat (5) queue_pixel(RED_W'($urandom_range(1, 255)));
      end
      finish_phase();

      if (error_count == 0) begin
         $display("text_line_char_segmenter verification clean");
      end else begin
         $display("text_line_char_segmenter verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("text_line_char_segmenter verification failed");
      $finish;
   end

endmodule
